// ----- hdl/gbts_pkg.sv -----
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared types and constants for the gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

   localparam int DATA_W  = 8;
   localparam int FIELD_W = 13;
   localparam int KIND_W  = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT   = 3'd0,
      KIND_DEL_FWD  = 3'd1,
      KIND_DEL_BACK = 3'd2,
      KIND_MOVE     = 3'd3,
      KIND_READ     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_READ_WAIT
   } state_type;

endpackage

// ----- hdl/gbts_mem.sv -----
// ----------------------------------------------------------------------------
// gbts_mem
// Byte store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gbts_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [gbts_pkg::DATA_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [gbts_pkg::DATA_W-1:0] rd_data
);

   logic [gbts_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [gbts_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/gap_buffer_text_store_top.sv -----
// Insert, delete and unused kinds give their result in the cycle after the beat;
// a read inside the text gives it through the store's read register and the result
// register, one beyond by the result register only; a move when the gap meets its target.
// Throughput: one beat per cycle for inserts and deletes while rsp_ready is high, set
// by the result register; a move copies each byte as a registered store read, then its write.
// Reset sets gap start 0, gap end CAPACITY, result valid 0; the byte store is not cleared.
// ----------------------------------------------------------------------------
// gap_buffer_text_store_top
// Gap buffer byte store with a small sequencer that drives the gap pointers
// and the byte memory, one byte per step.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_top #(
   parameter int CAPACITY = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [gbts_pkg::KIND_W-1:0]  req_kind,
   input  logic [gbts_pkg::DATA_W-1:0]  req_data_byte,
   input  logic [gbts_pkg::FIELD_W-1:0] req_position,
   input  logic [gbts_pkg::FIELD_W-1:0] req_count,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gbts_pkg::DATA_W-1:0]  rsp_read_byte,
   output logic [gbts_pkg::FIELD_W-1:0] rsp_text_length,
   output logic [gbts_pkg::FIELD_W-1:0] rsp_cursor,
   output logic                         rsp_full_res
);

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int CW = (PW > gbts_pkg::FIELD_W) ? PW : gbts_pkg::FIELD_W;
   localparam logic [PW-1:0] CAP = PW'(CAPACITY);

   gbts_pkg::state_type state_ff, state_in;
   logic [PW-1:0] gs_ff, gs_in;
   logic [PW-1:0] ge_ff, ge_in;
   logic [PW-1:0] target_ff, target_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [gbts_pkg::DATA_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic rsp_full_ff, rsp_full_in;

   logic mem_we;
   logic [AW-1:0] mem_wa;
   logic [gbts_pkg::DATA_W-1:0] mem_wd;
   logic mem_re;
   logic [AW-1:0] mem_ra;
   logic [gbts_pkg::DATA_W-1:0] mem_rd;

   logic [PW-1:0] gap_len;
   logic [PW-1:0] text_len;
   logic [CW-1:0] pos_c;
   logic [CW-1:0] cnt_c;
   logic [CW-1:0] read_idx;
   logic accept;

   gbts_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign gap_len  = ge_ff - gs_ff;
   assign text_len = CAP - gap_len;
   assign pos_c    = CW'(req_position);
   assign cnt_c    = CW'(req_count);
   assign read_idx = (pos_c < CW'(gs_ff)) ? pos_c : pos_c + CW'(gap_len);

   assign req_ready = (state_ff == gbts_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbts_pkg::ST_IDLE;
         gs_ff        <= '0;
         ge_ff        <= CAP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gs_ff        <= gs_in;
         ge_ff        <= ge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      wa_ff       <= wa_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_full_ff <= rsp_full_in;
   end

   always_comb begin
      state_in     = state_ff;
      gs_in        = gs_ff;
      ge_in        = ge_ff;
      target_in    = target_ff;
      wa_in        = wa_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_full_in  = rsp_full_ff;
      mem_we       = 1'b0;
      mem_wa       = gs_ff[AW-1:0];
      mem_wd       = req_data_byte;
      mem_re       = 1'b0;
      mem_ra       = read_idx[AW-1:0];

      unique case (state_ff)
         gbts_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_byte_in = '0;
               rsp_full_in = 1'b0;
               unique case (gbts_pkg::kind_type'(req_kind))
                  gbts_pkg::KIND_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (gs_ff == ge_ff) begin
                        rsp_full_in = 1'b1;
                     end else begin
                        mem_we = 1'b1;
                        gs_in  = gs_ff + PW'(1);
                     end
                  end
                  gbts_pkg::KIND_DEL_FWD: begin
                     rsp_valid_in = 1'b1;
                     if (cnt_c > CW'(CAP - ge_ff)) begin
                        ge_in = CAP;
                     end else begin
                        ge_in = ge_ff + PW'(req_count);
                     end
                  end
                  gbts_pkg::KIND_DEL_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (cnt_c > CW'(gs_ff)) begin
                        gs_in = '0;
                     end else begin
                        gs_in = gs_ff - PW'(req_count);
                     end
                  end
                  gbts_pkg::KIND_MOVE: begin
                     state_in = gbts_pkg::ST_MOVE_RD;
                     if (pos_c > CW'(text_len)) begin
                        target_in = text_len;
                     end else begin
                        target_in = PW'(req_position);
                     end
                  end
                  gbts_pkg::KIND_READ: begin
                     if (pos_c >= CW'(text_len)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = gbts_pkg::ST_READ_WAIT;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         gbts_pkg::ST_MOVE_RD: begin
            priority if (target_ff < gs_ff) begin
               mem_re   = 1'b1;
               mem_ra   = AW'(gs_ff - PW'(1));
               gs_in    = gs_ff - PW'(1);
               ge_in    = ge_ff - PW'(1);
               wa_in    = AW'(ge_ff - PW'(1));
               state_in = gbts_pkg::ST_MOVE_WR;
            end else if (target_ff > gs_ff) begin
               mem_re   = 1'b1;
               mem_ra   = ge_ff[AW-1:0];
               gs_in    = gs_ff + PW'(1);
               ge_in    = ge_ff + PW'(1);
               wa_in    = gs_ff[AW-1:0];
               state_in = gbts_pkg::ST_MOVE_WR;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               rsp_full_in  = 1'b0;
               state_in     = gbts_pkg::ST_IDLE;
            end
         end
         gbts_pkg::ST_MOVE_WR: begin
            mem_we   = 1'b1;
            mem_wa   = wa_ff;
            mem_wd   = mem_rd;
            state_in = gbts_pkg::ST_MOVE_RD;
         end
         gbts_pkg::ST_READ_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = mem_rd;
            rsp_full_in  = 1'b0;
            state_in     = gbts_pkg::ST_IDLE;
         end
         default: begin
            state_in = gbts_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_byte   = rsp_byte_ff;
   assign rsp_text_length = gbts_pkg::FIELD_W'(CW'(text_len));
   assign rsp_cursor      = gbts_pkg::FIELD_W'(CW'(gs_ff));
   assign rsp_full_res    = rsp_full_ff;

   // gap pointers stay ordered and inside the store
   a_gap_order: assert property (@(posedge clock) disable iff (reset)
      gs_ff <= ge_ff)
      else $error("gap start passed gap end");

   a_gap_bound: assert property (@(posedge clock) disable iff (reset)
      ge_ff <= CAP)
      else $error("gap end beyond capacity");

   // a move that reached its target hands out its beat next cycle
   a_move_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gbts_pkg::ST_MOVE_RD && target_ff == gs_ff)
      |=> (rsp_valid_ff && state_ff == gbts_pkg::ST_IDLE))
      else $error("move finished without a result beat");

   // no result is pending while a move is copying
   a_move_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gbts_pkg::ST_MOVE_WR) |-> !rsp_valid_ff)
      else $error("result pending during move");

endmodule

// ----- verif/gap_buffer_text_store_top_test.sv -----
// ----------------------------------------------------------------------------
// gap_buffer_text_store_top_test
// Self-checking bench for the gap buffer text store. A short table of edits
// covers empty text, clamped deletes, saturated moves, reads out of
// range and the unused kinds. Random edits then follow under several idle and
// stall patterns, including one long receiver hold. Every result beat is
// compared with a typed row's status, else a shadow gap buffer in the bench.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_top_test;

   localparam int STORE_BYTES = 4096;
   localparam logic [gbts_pkg::FIELD_W-1:0] FIELD_MAX = 13'h1FFF;
   localparam logic [gbts_pkg::KIND_W-1:0] KIND_SPARE5 = 3'd5;
   localparam logic [gbts_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
   localparam logic [gbts_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int RANDOM_PER_PHASE = 460;
   localparam int TEXT_SOFT_LIMIT = 192;

   typedef struct packed {
      logic [gbts_pkg::DATA_W-1:0]  read_byte;
      logic [gbts_pkg::FIELD_W-1:0] text_length;
      logic [gbts_pkg::FIELD_W-1:0] cursor;
      logic                         full_res;
   } text_status_type;

   typedef struct packed {
      logic [gbts_pkg::KIND_W-1:0]  kind;
      logic [gbts_pkg::DATA_W-1:0]  data_byte;
      logic [gbts_pkg::FIELD_W-1:0] position;
      logic [gbts_pkg::FIELD_W-1:0] count;
      logic                         typed;
      text_status_type              want;
   } edit_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [gbts_pkg::KIND_W-1:0]   req_kind = '0;
   logic [gbts_pkg::DATA_W-1:0]   req_data_byte = '0;
   logic [gbts_pkg::FIELD_W-1:0]  req_position = '0;
   logic [gbts_pkg::FIELD_W-1:0]  req_count = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [gbts_pkg::DATA_W-1:0]   rsp_read_byte;
   logic [gbts_pkg::FIELD_W-1:0]  rsp_text_length;
   logic [gbts_pkg::FIELD_W-1:0]  rsp_cursor;
   logic                          rsp_full_res;

   gap_buffer_text_store_top #(.CAPACITY(STORE_BYTES)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .req_position    (req_position),
      .req_count       (req_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_text_length (rsp_text_length),
      .rsp_cursor      (rsp_cursor),
      .rsp_full_res    (rsp_full_res)
   );

   // shadow gap buffer
   logic [gbts_pkg::DATA_W-1:0] shadow_text [STORE_BYTES];
   int                          shadow_gap_start = 0;
   int                          shadow_gap_end = STORE_BYTES;

   text_status_type pending_status [$];
   text_status_type due_status;
   int              mismatch_count = 0;
   int              send_idle_pct = 0;
   int              ready_stall_pct = 0;
   int              long_hold_req = 0;
   int              long_hold_seen = 0;
   int              hold_left = 0;

   edit_row_type edit_table [25] = '{
      '{gbts_pkg::KIND_READ, 8'h00, 13'd0, 13'd0, 1'b1, '{8'h00, 13'd0, 13'd0, 1'b0}},
      '{gbts_pkg::KIND_DEL_FWD, 8'h00, 13'd0, FIELD_MAX, 1'b1, '{8'h00, 13'd0, 13'd0, 1'b0}},
      '{gbts_pkg::KIND_DEL_BACK, 8'h00, 13'd0, FIELD_MAX, 1'b1, '{8'h00, 13'd0, 13'd0, 1'b0}},
      '{gbts_pkg::KIND_MOVE, 8'h00, FIELD_MAX, 13'd0, 1'b1, '{8'h00, 13'd0, 13'd0, 1'b0}},
      '{KIND_SPARE7, 8'hFF, FIELD_MAX, FIELD_MAX, 1'b1, '{8'h00, 13'd0, 13'd0, 1'b0}},
      '{gbts_pkg::KIND_INSERT, 8'hFF, 13'd0, 13'd0, 1'b1, '{8'h00, 13'd1, 13'd1, 1'b0}},
      '{gbts_pkg::KIND_INSERT, 8'h00, 13'd0, 13'd0, 1'b1, '{8'h00, 13'd2, 13'd2, 1'b0}},
      '{gbts_pkg::KIND_INSERT, 8'h5A, FIELD_MAX, FIELD_MAX, 1'b1, '{8'h00, 13'd3, 13'd3, 1'b0}},
      '{gbts_pkg::KIND_READ, 8'h00, 13'd0, 13'd0, 1'b1, '{8'hFF, 13'd3, 13'd3, 1'b0}},
      '{gbts_pkg::KIND_READ, 8'h00, 13'd3, 13'd0, 1'b1, '{8'h00, 13'd3, 13'd3, 1'b0}},
      '{gbts_pkg::KIND_READ, 8'hFF, FIELD_MAX, FIELD_MAX, 1'b1, '{8'h00, 13'd3, 13'd3, 1'b0}},
      '{gbts_pkg::KIND_MOVE, 8'h00, 13'd0, 13'd0, 1'b1, '{8'h00, 13'd3, 13'd0, 1'b0}},
      '{gbts_pkg::KIND_READ, 8'h00, 13'd2, 13'd0, 1'b1, '{8'h5A, 13'd3, 13'd0, 1'b0}},
      '{gbts_pkg::KIND_INSERT, 8'hA5, 13'd0, 13'd0, 1'b1, '{8'h00, 13'd4, 13'd1, 1'b0}},
      '{gbts_pkg::KIND_MOVE, 8'h00, 13'd2, 13'd0, 1'b1, '{8'h00, 13'd4, 13'd2, 1'b0}},
      '{gbts_pkg::KIND_READ, 8'h00, 13'd1, 13'd0, 1'b1, '{8'hFF, 13'd4, 13'd2, 1'b0}},
      '{gbts_pkg::KIND_DEL_FWD, 8'h00, 13'd0, 13'd1, 1'b1, '{8'h00, 13'd3, 13'd2, 1'b0}},
      '{KIND_SPARE5, 8'h00, 13'd0, 13'd0, 1'b1, '{8'h00, 13'd3, 13'd2, 1'b0}},
      '{gbts_pkg::KIND_DEL_BACK, 8'h00, 13'd0, 13'd1, 1'b1, '{8'h00, 13'd2, 13'd1, 1'b0}},
      '{KIND_SPARE6, 8'h00, 13'd0, 13'd0, 1'b1, '{8'h00, 13'd2, 13'd1, 1'b0}},
      '{gbts_pkg::KIND_MOVE, 8'h00, 13'd4096, 13'd0, 1'b1, '{8'h00, 13'd2, 13'd2, 1'b0}},
      '{gbts_pkg::KIND_DEL_BACK, 8'h00, 13'd0, 13'd0, 1'b1, '{8'h00, 13'd2, 13'd2, 1'b0}},
      '{gbts_pkg::KIND_READ, 8'h00, 13'd1, 13'd0, 1'b0, '0},
      '{gbts_pkg::KIND_MOVE, 8'h00, 13'd1, 13'd0, 1'b0, '0},
      '{gbts_pkg::KIND_DEL_FWD, 8'h00, 13'd0, FIELD_MAX, 1'b0, '0}
   };

   function automatic int shadow_length();
      return STORE_BYTES - (shadow_gap_end - shadow_gap_start);
   endfunction

   function automatic text_status_type apply_edit(
         input logic [gbts_pkg::KIND_W-1:0] kind,
         input logic [gbts_pkg::DATA_W-1:0] data_byte,
         input logic [gbts_pkg::FIELD_W-1:0] position,
         input logic [gbts_pkg::FIELD_W-1:0] count);
      text_status_type result;
      int target;
      int avail;
      int idx;
      result = '0;
      case (kind)
         gbts_pkg::KIND_INSERT: begin
            if (shadow_gap_start >= shadow_gap_end) begin
               result.full_res = 1'b1;
            end else begin
               shadow_text[shadow_gap_start] = data_byte;
               shadow_gap_start++;
            end
         end
         gbts_pkg::KIND_DEL_FWD: begin
            avail = STORE_BYTES - shadow_gap_end;
            shadow_gap_end += (int'(count) > avail) ? avail : int'(count);
         end
         gbts_pkg::KIND_DEL_BACK: begin
            avail = shadow_gap_start;
            shadow_gap_start -= (int'(count) > avail) ? avail : int'(count);
         end
         gbts_pkg::KIND_MOVE: begin
            target = int'(position);
            if (target > shadow_length()) target = shadow_length();
            while (target < shadow_gap_start) begin
               shadow_gap_start--;
               shadow_gap_end--;
               shadow_text[shadow_gap_end] = shadow_text[shadow_gap_start];
            end
            while (target > shadow_gap_start) begin
               shadow_text[shadow_gap_start] = shadow_text[shadow_gap_end];
               shadow_gap_start++;
               shadow_gap_end++;
            end
         end
         gbts_pkg::KIND_READ: begin
            if (int'(position) < shadow_length()) begin
               idx = int'(position);
               if (idx >= shadow_gap_start) idx += shadow_gap_end - shadow_gap_start;
               if (idx < STORE_BYTES) result.read_byte = shadow_text[idx];
            end
         end
         default: begin
         end
      endcase
      result.text_length = gbts_pkg::FIELD_W'(shadow_length());
      result.cursor = gbts_pkg::FIELD_W'(shadow_gap_start);
      return result;
   endfunction

   task automatic offer_beat(input logic [gbts_pkg::KIND_W-1:0] kind,
                             input logic [gbts_pkg::DATA_W-1:0] data_byte,
                             input logic [gbts_pkg::FIELD_W-1:0] position,
                             input logic [gbts_pkg::FIELD_W-1:0] count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_data_byte <= data_byte;
      req_position <= position;
      req_count <= count;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic issue_edit(input logic [gbts_pkg::KIND_W-1:0] kind,
                             input logic [gbts_pkg::DATA_W-1:0] data_byte,
                             input logic [gbts_pkg::FIELD_W-1:0] position,
                             input logic [gbts_pkg::FIELD_W-1:0] count);
      offer_beat(kind, data_byte, position, count);
      pending_status.push_back(apply_edit(kind, data_byte, position, count));
   endtask

   task automatic random_edit();
      int len;
      int pick;
      logic [gbts_pkg::KIND_W-1:0] kind;
      logic [gbts_pkg::FIELD_W-1:0] position;
      logic [gbts_pkg::FIELD_W-1:0] count;
      len = shadow_length();
      pick = $urandom_range(99);
      if (pick < 40)
         kind = (len >= TEXT_SOFT_LIMIT) ? gbts_pkg::KIND_DEL_BACK : gbts_pkg::KIND_INSERT;
      else if (pick < 58) kind = gbts_pkg::KIND_READ;
      else if (pick < 70) kind = gbts_pkg::KIND_MOVE;
      else if (pick < 80) kind = gbts_pkg::KIND_DEL_FWD;
      else if (pick < 97) kind = gbts_pkg::KIND_DEL_BACK;
      else kind = gbts_pkg::KIND_W'($urandom_range(int'(KIND_SPARE5), int'(KIND_SPARE7)));
      if ($urandom_range(99) < 85) position = gbts_pkg::FIELD_W'($urandom_range(0, len + 2));
      else position = gbts_pkg::FIELD_W'($urandom);
      pick = $urandom_range(99);
      if (len >= TEXT_SOFT_LIMIT && kind == gbts_pkg::KIND_DEL_BACK)
         count = gbts_pkg::FIELD_W'($urandom_range(1, 96));
      else if (pick < 80) count = gbts_pkg::FIELD_W'($urandom_range(0, 8));
      else if (pick < 90) count = gbts_pkg::FIELD_W'($urandom_range(0, 64));
      else count = gbts_pkg::FIELD_W'($urandom);
      issue_edit(kind, gbts_pkg::DATA_W'($urandom), position, count);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // result side: check each beat, then decide next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            $display("%0t unexpected beat: read_byte %0h length %0d cursor %0d full %0b",
                     $time, rsp_read_byte, rsp_text_length, rsp_cursor, rsp_full_res);
            mismatch_count++;
         end else begin
            due_status = pending_status.pop_front();
            if (rsp_read_byte !== due_status.read_byte) begin
               $display("%0t read_byte: expected %0h, actual %0h",
                        $time, due_status.read_byte, rsp_read_byte);
               mismatch_count++;
            end
            if (rsp_text_length !== due_status.text_length) begin
               $display("%0t text_length: expected %0d, actual %0d",
                        $time, due_status.text_length, rsp_text_length);
               mismatch_count++;
            end
            if (rsp_cursor !== due_status.cursor) begin
               $display("%0t cursor: expected %0d, actual %0d",
                        $time, due_status.cursor, rsp_cursor);
               mismatch_count++;
            end
            if (rsp_full_res !== due_status.full_res) begin
               $display("%0t full_res: expected %0b, actual %0b",
                        $time, due_status.full_res, rsp_full_res);
               mismatch_count++;
            end
         end
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold_seen != long_hold_req) begin
         long_hold_seen = long_hold_req;
         hold_left = LONG_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= ready_stall_pct);
      end
   end

   initial begin
      int drain_left;
      text_status_type row_status;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (edit_table[i]) begin
         offer_beat(edit_table[i].kind, edit_table[i].data_byte,
                    edit_table[i].position, edit_table[i].count);
         row_status = apply_edit(edit_table[i].kind, edit_table[i].data_byte,
                                 edit_table[i].position, edit_table[i].count);
         pending_status.push_back(edit_table[i].typed ? edit_table[i].want : row_status);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               ready_stall_pct = 0;
               long_hold_req++;
            end
            1: begin
               send_idle_pct = 69;
               ready_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               ready_stall_pct = 69;
            end
            default: begin
               send_idle_pct = 15;
               ready_stall_pct = 15;
               // move the cursor and read at position 0 and at the top of the store
               issue_edit(gbts_pkg::KIND_READ, 8'h00, 13'd0, 13'd0);
               issue_edit(gbts_pkg::KIND_READ, 8'h00, 13'd4095, 13'd0);
               issue_edit(gbts_pkg::KIND_READ, 8'h00, 13'd4096, 13'd0);
               issue_edit(gbts_pkg::KIND_MOVE, 8'h00, 13'd0, 13'd0);
               issue_edit(gbts_pkg::KIND_INSERT, 8'h3C, 13'd0, 13'd0);
               issue_edit(gbts_pkg::KIND_READ, 8'h00, 13'd4095, 13'd0);
               issue_edit(gbts_pkg::KIND_MOVE, 8'h00, 13'd2048, 13'd0);
               repeat (4) issue_edit(gbts_pkg::KIND_READ, 8'h00,
                                     gbts_pkg::FIELD_W'($urandom_range(0, 4095)), 13'd0);
               issue_edit(gbts_pkg::KIND_DEL_FWD, 8'h00, 13'd0, FIELD_MAX);
               issue_edit(gbts_pkg::KIND_DEL_BACK, 8'h00, 13'd0, FIELD_MAX);
            end
         endcase
         repeat (RANDOM_PER_PHASE) random_edit();
      end
      req_valid <= 1'b0;

      while (pending_status.size() != 0) @(posedge clock);
      drain_left = 20;
      while (drain_left != 0) begin
         @(posedge clock);
         drain_left--;
      end
      if (mismatch_count == 0 && pending_status.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/gbts_pkg.sv
hdl/gbts_mem.sv
hdl/gap_buffer_text_store_top.sv
verif/gap_buffer_text_store_top_test.sv
